// ----- hw/rtl/lsp_pkg.sv -----
// ---------------------------------------------------------------------------
// lsp_pkg: load segment planner shared definitions
// Status codes, section codes and the structs passed between the planner
// datapath and the top level.
// ---------------------------------------------------------------------------
package lsp_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_PLANNED   = 3'd0,
        ST_SKIPPED   = 3'd1,
        ST_TOO_MANY  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_WRITE_EXEC = 3'd4,
        ST_SUMMARY   = 3'd5,
        ST_NO_SEGS   = 3'd6,
        ST_ABORTED   = 3'd7
    } t_status;

    // Section kinds
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_RODATA = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_BSS    = 2'd3;

    // Section types
    localparam logic [1:0] STYPE_LOADED = 2'd1;
    localparam logic [1:0] STYPE_ZERO   = 2'd2;

    // Item modes and header type of a loadable segment
    localparam logic        MODE_RECORD = 1'b0;
    localparam logic        MODE_FINISH = 1'b1;
    localparam logic [31:0] PT_LOAD     = 32'd1;

    // Output alignment of loaded sections, as a low-bit mask width
    localparam int ALIGN_BITS = 4;

    typedef struct packed {
        logic        mode;
        logic [31:0] seg_type;
        logic [2:0]  seg_perm;
        logic [63:0] seg_file_offset;
        logic [63:0] seg_file_bytes;
        logic [63:0] seg_mem_bytes;
        logic [63:0] seg_vaddr;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  section_index;
        logic [1:0]  section_kind;
        logic [1:0]  section_type;
        logic [2:0]  section_perm;
        logic [63:0] out_offset;
        logic [4:0]  total_sections;
        logic [63:0] lowest_vaddr;
        logic [63:0] highest_vaddr_end;
        logic [63:0] output_size;
    } t_result;

    // Running image state, apart from the section count
    typedef struct packed {
        logic [63:0] cursor;
        logic [63:0] min_addr;
        logic [63:0] max_addr;
        logic        error;
    } t_plan_state;

endpackage

// ----- hw/rtl/lsp_plan.sv -----
// ---------------------------------------------------------------------------
// lsp_plan: single-pass segment planning datapath
// Checks one registered record against the running state and forms its
// result together with the next state.
// ---------------------------------------------------------------------------
module lsp_plan #(
    parameter int MAX_SECTIONS      = 16,
    parameter int HEADER_PAGE_BYTES = 4096,
    parameter int CNT_W             = $clog2(MAX_SECTIONS + 1)
) (
    input  lsp_pkg::t_item       i_item,
    input  lsp_pkg::t_plan_state i_state,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [31:0]          i_image_length,
    output lsp_pkg::t_result     o_result,
    output lsp_pkg::t_plan_state o_state,
    output logic [CNT_W-1:0]     o_count
);
    import lsp_pkg::*;

    localparam logic [63:0]      CURSOR_INIT = 64'(HEADER_PAGE_BYTES);
    localparam logic [CNT_W-1:0] CNT_LIMIT   = CNT_W'(MAX_SECTIONS);

    logic [6:0]  cnt_ext;
    logic        at_limit;
    logic [64:0] file_end;
    logic        truncated;
    logic        write_exec;
    logic        skip;
    logic [2:0]  flags;
    logic        zero_file;
    logic [1:0]  kind;
    logic [63:0] cursor_aligned;
    logic [63:0] seg_end;
    t_plan_state clear_state;

    // Checks on the record
    assign cnt_ext    = 7'(i_count);
    assign at_limit   = (i_count >= CNT_LIMIT);
    assign file_end   = {1'b0, i_item.seg_file_offset} + {1'b0, i_item.seg_file_bytes};
    assign truncated  = (file_end > 65'(i_image_length));
    assign write_exec = (i_item.seg_perm[1:0] == 2'b11);
    assign skip       = (i_item.seg_type != PT_LOAD) || (i_item.seg_mem_bytes == 64'd0);

    // Map permissions: read to bit0, write to bit1, execute to bit2
    assign flags     = {i_item.seg_perm[0], i_item.seg_perm[1], i_item.seg_perm[2]};
    assign zero_file = (i_item.seg_file_bytes == 64'd0);

    always_comb begin
        if (flags[2]) begin
            kind = KIND_TEXT;
        end else if (flags[1]) begin
            kind = zero_file ? KIND_BSS : KIND_DATA;
        end else begin
            kind = KIND_RODATA;
        end
    end

    // Round the cursor up to the output alignment, wrapping at 2^64
    assign cursor_aligned = {i_state.cursor[63:ALIGN_BITS]
                                 + (64-ALIGN_BITS)'(|i_state.cursor[ALIGN_BITS-1:0]),
                             {ALIGN_BITS{1'b0}}};
    assign seg_end = i_item.seg_vaddr + i_item.seg_mem_bytes;

    assign clear_state = '{cursor: CURSOR_INIT, min_addr: '1, max_addr: '0, error: 1'b0};

    // Result and next state
    always_comb begin
        o_result = '0;
        o_state  = i_state;
        o_count  = i_count;
        if (i_item.mode == MODE_FINISH) begin
            if (i_state.error) begin
                o_result.status = ST_ABORTED;
            end else if (i_count == '0) begin
                o_result.status = ST_NO_SEGS;
            end else begin
                o_result.status            = ST_SUMMARY;
                o_result.total_sections    = cnt_ext[4:0];
                o_result.lowest_vaddr      = i_state.min_addr;
                o_result.highest_vaddr_end = i_state.max_addr;
                o_result.output_size       = i_state.cursor;
            end
            o_state = clear_state;
            o_count = '0;
        end else if (i_state.error) begin
            o_result.status = ST_ABORTED;
        end else if (skip) begin
            o_result.status = ST_SKIPPED;
        end else if (at_limit) begin
            o_result.status = ST_TOO_MANY;
            o_state.error   = 1'b1;
        end else if (truncated) begin
            o_result.status = ST_TRUNCATED;
            o_state.error   = 1'b1;
        end else if (write_exec) begin
            o_result.status = ST_WRITE_EXEC;
            o_state.error   = 1'b1;
        end else begin
            o_result.status        = ST_PLANNED;
            o_result.section_index = cnt_ext[3:0];
            o_result.section_kind  = kind;
            o_result.section_perm  = flags;
            if (zero_file) begin
                o_result.section_type = STYPE_ZERO;
            end else begin
                o_result.section_type = STYPE_LOADED;
                o_result.out_offset   = cursor_aligned;
                o_state.cursor        = cursor_aligned + i_item.seg_file_bytes;
            end
            if (i_item.seg_vaddr < i_state.min_addr) begin
                o_state.min_addr = i_item.seg_vaddr;
            end
            if (seg_end > i_state.max_addr) begin
                o_state.max_addr = seg_end;
            end
            o_count = i_count + CNT_W'(1);
        end
    end

endmodule

// ----- hw/rtl/load_segment_planner_unit.sv -----
// ---------------------------------------------------------------------------
// load_segment_planner_unit: loadable segment planner
// Plans output sections from ELF64 program-header records and reports a
// summary of the image on a finish item.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one program-header record
//   or a finish item (i_mode = 1). A transfer happens on a clock edge with
//   valid high and stall low. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result per item, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the image length;
//   it is always ready and should be written only while the unit is idle.
// Path: from input transfer to result transfer through the input register,
//   then the result register. Throughput: one item per cycle while
//   i_out_stall holds no result; the planning loop on the cursor, address
//   range and count closes through the running-state registers.
// Stall: while the result register is held by i_out_stall, one more item is
//   still taken into the input register; after that o_in_stall rises.
// Reset: synchronous, active low; clears both stages, sets the cursor to the
//   header page size, the range to empty, count and error flag to zero, and
//   the image length to zero.
// ---------------------------------------------------------------------------
module load_segment_planner_unit #(
    parameter int MAX_SECTIONS      = 16,
    parameter int HEADER_PAGE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // input records
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_seg_type,
    input  logic [2:0]  i_seg_perm,
    input  logic [63:0] i_seg_file_offset,
    input  logic [63:0] i_seg_file_bytes,
    input  logic [63:0] i_seg_mem_bytes,
    input  logic [63:0] i_seg_vaddr,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_section_index,
    output logic [1:0]  o_section_kind,
    output logic [1:0]  o_section_type,
    output logic [2:0]  o_section_perm,
    output logic [63:0] o_out_offset,
    output logic [4:0]  o_total_sections,
    output logic [63:0] o_lowest_vaddr,
    output logic [63:0] o_highest_vaddr_end,
    output logic [63:0] o_output_size
);
    import lsp_pkg::*;

    localparam int          CNT_W       = $clog2(MAX_SECTIONS + 1);
    localparam logic [63:0] CURSOR_INIT = 64'(HEADER_PAGE_BYTES);

    logic             r_in_valid;
    t_item            r_item;
    logic             r_out_valid;
    t_result          r_result;
    t_plan_state      r_state;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_image_length;

    t_item            in_item;
    t_result          n_result;
    t_plan_state      n_state;
    logic [CNT_W-1:0] n_count;
    logic             out_free;
    logic             fire;
    logic             in_accept;

    // Handshake: the record stage moves when the result register can load
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign in_item = '{mode: i_mode, seg_type: i_seg_type, seg_perm: i_seg_perm,
                       seg_file_offset: i_seg_file_offset,
                       seg_file_bytes: i_seg_file_bytes,
                       seg_mem_bytes: i_seg_mem_bytes, seg_vaddr: i_seg_vaddr};

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_image_length <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= in_item;
        end
    end

    lsp_plan #(
        .MAX_SECTIONS      (MAX_SECTIONS),
        .HEADER_PAGE_BYTES (HEADER_PAGE_BYTES),
        .CNT_W             (CNT_W)
    ) u_plan (
        .i_item         (r_item),
        .i_state        (r_state),
        .i_count        (r_count),
        .i_image_length (r_image_length),
        .o_result       (n_result),
        .o_state        (n_state),
        .o_count        (n_count)
    );

    // Advance the running state on each transfer out of the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{cursor: CURSOR_INIT, min_addr: '1, max_addr: '0, error: 1'b0};
            r_count <= '0;
        end else if (fire) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Result register: load on fire, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_result.status;
    assign o_section_index     = r_result.section_index;
    assign o_section_kind      = r_result.section_kind;
    assign o_section_type      = r_result.section_type;
    assign o_section_perm      = r_result.section_perm;
    assign o_out_offset        = r_result.out_offset;
    assign o_total_sections    = r_result.total_sections;
    assign o_lowest_vaddr      = r_result.lowest_vaddr;
    assign o_highest_vaddr_end = r_result.highest_vaddr_end;
    assign o_output_size       = r_result.output_size;

    // Section count never passes the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SECTIONS))
        else $error("section count above limit");

    // An empty plan keeps the address range empty
    a_empty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_state.min_addr == '1))
        else $error("address range set with no planned section");

    // A record after an error reports aborted
    a_abort_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_state.error && r_item.mode == MODE_RECORD)
            |=> (o_out_valid && o_status == ST_ABORTED))
        else $error("record after error not aborted");

    // A planned section bumps the count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_result.status == ST_PLANNED)
            |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("count did not advance on planned section");

    // Loaded sections sit on an aligned offset
    a_offset_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_PLANNED && o_section_type == STYPE_LOADED)
            |-> (o_out_offset[ALIGN_BITS-1:0] == '0))
        else $error("loaded section offset not aligned");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: load segment planner unit testbench
// Feeds program-header records and finish items through the valid/stall
// input channel and predicts each result with a cycle-free planner model
// kept alongside. Results are compared field by field in order. The image
// length register is rewritten between idle phases. The sender and the
// receiver idle at random, first one side heavily, then the other, then
// neither.
// ---------------------------------------------------------------------------
module tb_top;
    import lsp_pkg::*;

    localparam int MAX_SECT    = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int CHUNK_ITEMS = 90;
    localparam logic [63:0] OUT_ALIGN = 64'd16;
    // Segment permission bits as they arrive
    localparam logic [2:0] PERM_X = 3'b001;
    localparam logic [2:0] PERM_W = 3'b010;
    localparam logic [2:0] PERM_R = 3'b100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        i_out_stall = 1'b0;
    t_item       drv_item = '0;

    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_section_index;
    logic [1:0]  o_section_kind;
    logic [1:0]  o_section_type;
    logic [2:0]  o_section_perm;
    logic [63:0] o_out_offset;
    logic [4:0]  o_total_sections;
    logic [63:0] o_lowest_vaddr;
    logic [63:0] o_highest_vaddr_end;
    logic [63:0] o_output_size;

    // Records waiting to be driven and planner outcomes waiting to come back
    t_item   header_q[$];
    t_result outcome_q[$];

    // Planner state as predicted
    logic [63:0] cursor;
    logic [63:0] lo_addr;
    logic [63:0] hi_end;
    int          sect_count;
    bit          seen_error;
    logic [31:0] img_len;

    bit in_taken;
    int mismatch_cnt = 0;
    int send_idle_pct = 28;
    int recv_idle_pct = 79;

    load_segment_planner_unit #(
        .MAX_SECTIONS      (MAX_SECT),
        .HEADER_PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_mode              (drv_item.mode),
        .i_seg_type          (drv_item.seg_type),
        .i_seg_perm          (drv_item.seg_perm),
        .i_seg_file_offset   (drv_item.seg_file_offset),
        .i_seg_file_bytes    (drv_item.seg_file_bytes),
        .i_seg_mem_bytes     (drv_item.seg_mem_bytes),
        .i_seg_vaddr         (drv_item.seg_vaddr),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_section_index     (o_section_index),
        .o_section_kind      (o_section_kind),
        .o_section_type      (o_section_type),
        .o_section_perm      (o_section_perm),
        .o_out_offset        (o_out_offset),
        .o_total_sections    (o_total_sections),
        .o_lowest_vaddr      (o_lowest_vaddr),
        .o_highest_vaddr_end (o_highest_vaddr_end),
        .o_output_size       (o_output_size)
    );

    always #2 i_clk = ~i_clk;

    // Return the image state to empty
    function automatic void clear_plan();
        cursor     = 64'(PAGE_BYTES);
        lo_addr    = '1;
        hi_end     = '0;
        sect_count = 0;
        seen_error = 1'b0;
    endfunction

    // Plan one record or close the image, updating the predicted state
    function automatic t_result plan_outcome(input t_item rec);
        t_result     r;
        logic [64:0] span;
        logic [2:0]  flags;
        logic [63:0] end_addr;
        r = '0;
        if (rec.mode == MODE_FINISH) begin
            if (seen_error) begin
                r.status = ST_ABORTED;
            end else if (sect_count == 0) begin
                r.status = ST_NO_SEGS;
            end else begin
                r.status            = ST_SUMMARY;
                r.total_sections    = sect_count[4:0];
                r.lowest_vaddr      = lo_addr;
                r.highest_vaddr_end = hi_end;
                r.output_size       = cursor;
            end
            clear_plan();
            return r;
        end
        if (seen_error) begin
            r.status = ST_ABORTED;
            return r;
        end
        if (rec.seg_type != PT_LOAD || rec.seg_mem_bytes == '0) begin
            r.status = ST_SKIPPED;
            return r;
        end
        // Checks in priority order; the first hit poisons the image
        span = {1'b0, rec.seg_file_offset} + {1'b0, rec.seg_file_bytes};
        if (sect_count >= MAX_SECT) begin
            r.status = ST_TOO_MANY;
        end else if (span > {33'd0, img_len}) begin
            r.status = ST_TRUNCATED;
        end else if ((rec.seg_perm & (PERM_W | PERM_X)) == (PERM_W | PERM_X)) begin
            r.status = ST_WRITE_EXEC;
        end
        if (r.status != ST_PLANNED) begin
            seen_error = 1'b1;
            return r;
        end
        // Output flags: bit0 read, bit1 write, bit2 execute
        flags = {rec.seg_perm[0], rec.seg_perm[1], rec.seg_perm[2]};
        if (flags[2])
            r.section_kind = KIND_TEXT;
        else if (flags[1])
            r.section_kind = (rec.seg_file_bytes == '0) ? KIND_BSS : KIND_DATA;
        else
            r.section_kind = KIND_RODATA;
        r.section_type = (rec.seg_file_bytes == '0) ? STYPE_ZERO : STYPE_LOADED;
        // Align the cursor and advance it past the file bytes
        if (r.section_type == STYPE_LOADED) begin
            cursor = (cursor + OUT_ALIGN - 64'd1) & ~(OUT_ALIGN - 64'd1);
            r.out_offset = cursor;
            cursor = cursor + rec.seg_file_bytes;
        end
        end_addr = rec.seg_vaddr + rec.seg_mem_bytes;
        if (rec.seg_vaddr < lo_addr)
            lo_addr = rec.seg_vaddr;
        if (end_addr > hi_end)
            hi_end = end_addr;
        r.status        = ST_PLANNED;
        r.section_index = sect_count[3:0];
        r.section_perm  = flags;
        sect_count++;
        return r;
    endfunction

    function automatic t_item make_header(input logic [31:0] typ, input logic [2:0] perm,
                                          input logic [63:0] foff, input logic [63:0] fbytes,
                                          input logic [63:0] mbytes, input logic [63:0] vaddr);
        t_item h;
        h.mode            = MODE_RECORD;
        h.seg_type        = typ;
        h.seg_perm        = perm;
        h.seg_file_offset = foff;
        h.seg_file_bytes  = fbytes;
        h.seg_mem_bytes   = mbytes;
        h.seg_vaddr       = vaddr;
        return h;
    endfunction

    function automatic t_item finish_item();
        t_item h;
        h = '0;
        h.mode = MODE_FINISH;
        return h;
    endfunction

    // Loadable record that fits the image and avoids write plus execute
    function automatic t_item clean_header(input logic [31:0] len);
        t_item           h;
        longint unsigned cap;
        longint unsigned fb;
        h = '0;
        h.mode     = MODE_RECORD;
        h.seg_type = PT_LOAD;
        h.seg_perm = $urandom_range(0, 7);
        if ((h.seg_perm & (PERM_W | PERM_X)) == (PERM_W | PERM_X))
            h.seg_perm = h.seg_perm & ~PERM_X;
        cap = (len < 32'h4000) ? len : 32'h4000;
        if ($urandom_range(0, 19) == 0)
            fb = len;
        else if ($urandom_range(0, 3) == 0)
            fb = 0;
        else
            fb = {32'd0, $urandom} % (cap + 1);
        h.seg_file_bytes  = fb;
        h.seg_file_offset = {32'd0, $urandom} % ({32'd0, len} - fb + 1);
        if ($urandom_range(0, 7) == 0)
            h.seg_mem_bytes = {$urandom, $urandom} | 64'd1;
        else
            h.seg_mem_bytes = fb + $urandom_range(1, 32'h3000);
        if ($urandom_range(0, 1) == 0)
            h.seg_vaddr = {$urandom, $urandom};
        else
            h.seg_vaddr = 64'h40_0000 + ({32'd0, $urandom_range(0, 4095)} << 12);
        return h;
    endfunction

    // Anything at all: stray types, empty segments, early finish, bad ranges
    function automatic t_item noise_header();
        t_item h;
        h.mode     = ($urandom_range(0, 15) == 0) ? MODE_FINISH : MODE_RECORD;
        h.seg_type = ($urandom_range(0, 2) == 0) ? PT_LOAD : $urandom;
        h.seg_perm = $urandom_range(0, 7);
        h.seg_file_offset = ($urandom_range(0, 2) == 0) ?
                            {32'd0, $urandom_range(0, 4095)} : {$urandom, $urandom};
        h.seg_file_bytes  = ($urandom_range(0, 2) == 0) ?
                            {32'd0, $urandom_range(0, 4095)} : {$urandom, $urandom};
        h.seg_mem_bytes   = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
        h.seg_vaddr       = {$urandom, $urandom};
        return h;
    endfunction

    // One image: a run of mostly well-formed records closed by a finish
    task automatic queue_image(input logic [31:0] len, inout int added);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 8);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                header_q.push_back(noise_header());
            else
                header_q.push_back(clean_header(len));
        end
        header_q.push_back(finish_item());
        added += n + 1;
    endtask

    // Hold off until every record is sent and every result is back
    task automatic drain();
        while (header_q.size() != 0 || i_in_valid || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_image_length(input logic [31:0] len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 40)
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    // Drive records; a presented record holds until its transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (header_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drv_item   <= header_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Predict on each input transfer, check each result transfer
    always @(posedge i_clk) begin
        t_result want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken)
            outcome_q.push_back(plan_outcome(drv_item));
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            img_len = i_cfg_data;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: result with none expected, status %0h", $time, o_status);
            end else begin
                want = outcome_q.pop_front();
                check_field("status", want.status, o_status);
                check_field("section_index", want.section_index, o_section_index);
                check_field("section_kind", want.section_kind, o_section_kind);
                check_field("section_type", want.section_type, o_section_type);
                check_field("section_perm", want.section_perm, o_section_perm);
                check_field("out_offset", want.out_offset, o_out_offset);
                check_field("total_sections", want.total_sections, o_total_sections);
                check_field("lowest_vaddr", want.lowest_vaddr, o_lowest_vaddr);
                check_field("highest_vaddr_end", want.highest_vaddr_end,
                            o_highest_vaddr_end);
                check_field("output_size", want.output_size, o_output_size);
            end
        end
    end

    initial begin
        int          added;
        logic [31:0] lens [4];
        clear_plan();
        img_len = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, image length still at reset: empty finish, zero-fill
        // sections, truncation, abort and finish after an error
        header_q.push_back(finish_item());
        header_q.push_back(make_header(PT_LOAD, PERM_R, 0, 0, 64'h10, 64'h1000));
        header_q.push_back(make_header(PT_LOAD, PERM_R | PERM_W, 0, 0, 64'h2000, 64'h3000));
        header_q.push_back(make_header(PT_LOAD, PERM_R, 64'd1, 0, 64'h10, 64'h5000));
        header_q.push_back(make_header(PT_LOAD, PERM_R, 0, 0, 64'h10, 64'h6000));
        header_q.push_back(finish_item());
        drain();

        // Directed, full image length: skips, every kind, wrap of the end
        // address, summary, write plus execute, carry out of the file range
        write_image_length(32'hFFFF_FFFF);
        header_q.push_back(make_header(32'd2, PERM_R, 0, 64'h10, 64'h10, 64'h1000));
        header_q.push_back(make_header(32'hFFFF_FFFF, 3'b111, '1, '1, '1, '1));
        header_q.push_back(make_header(PT_LOAD, PERM_R, 64'h40, 64'h10, 0, 64'h2000));
        header_q.push_back(make_header(PT_LOAD, PERM_R | PERM_X, 64'h40, 64'h123, 64'h123,
                                       64'h40_0000));
        header_q.push_back(make_header(PT_LOAD, PERM_R, 64'h200, 64'h10, 64'h10, 64'h50_0000));
        header_q.push_back(make_header(PT_LOAD, PERM_R | PERM_W, 64'h300, 64'h5, 64'h1000,
                                       64'h60_0000));
        header_q.push_back(make_header(PT_LOAD, PERM_W, 0, 0, 64'h800, 64'h70_0000));
        header_q.push_back(make_header(PT_LOAD, PERM_X, 64'hFFFF_FF00, 64'hFF, 64'hFF,
                                       64'h80_0000));
        header_q.push_back(make_header(PT_LOAD, 3'b000, 0, 64'hFFFF_FFFF, '1, 0));
        header_q.push_back(make_header(PT_LOAD, PERM_R, 0, 0, 64'd2, '1));
        header_q.push_back(finish_item());
        header_q.push_back(make_header(PT_LOAD, PERM_W | PERM_X, 0, 64'h10, 64'h10, 64'h1000));
        header_q.push_back(finish_item());
        header_q.push_back(make_header(PT_LOAD, PERM_R, '1, 64'd1, 64'h10, 64'h1000));
        header_q.push_back(finish_item());
        drain();

        // Random images over three idling phases and four image lengths each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            lens = '{32'hFFFF_FFFF, $urandom, $urandom_range(0, 32'h8000), 32'h0};
            for (int c = 0; c < 4; c++) begin
                write_image_length(lens[c]);
                added = 0;
                while (added < CHUNK_ITEMS)
                    queue_image(lens[c], added);
                drain();
            end
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && outcome_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
